/* src/nms_pkg.sv */
// Shared types, constants and pixel decode for the windowed non-max suppression core.
// No dependencies.
package nms_pkg;

   localparam int VALUE_W   = 16;
   localparam int OUT_COL_W = 11;
   localparam int OUT_ROW_W = 12;
   localparam int WCFG_W    = 12;
   localparam int HCFG_W    = 13;
   localparam int WSCFG_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 2'd3;

   localparam logic FMT_U8  = 1'b0;
   localparam logic FMT_S16 = 1'b1;

   localparam logic [VALUE_W-1:0] S16_FLOOR = 16'h8000;

   typedef struct packed {
      logic               mask;
      logic [VALUE_W-1:0] value;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
   } meta_type;

   typedef struct packed {
      logic rd_en;
      logic shift;
   } lines_ctl_type;

   function automatic logic signed [VALUE_W:0] decode(input cell_type c, input logic fmt);
      logic signed [VALUE_W:0] v;
      if (fmt == FMT_U8) begin
         v = {9'b0, c.value[7:0]};
      end else begin
         v = {c.value[VALUE_W-1], c.value};
      end
      return v;
   endfunction

endpackage

/* src/nms_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module nms_ram #(
   parameter int DATA_W = 17,
   parameter int DEPTH  = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/nms_lines.sv */
// Line store cascade and square window registers of the non-max suppression core.
// Depends on nms_pkg and nms_ram.
module nms_lines #(
   parameter int MAX_WIDTH = 2048,
   parameter int WIN       = 9
) (
   input  logic                         clock,
   input  nms_pkg::lines_ctl_type       ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  nms_pkg::cell_type            new_cell,
   output nms_pkg::cell_type            win [WIN][WIN]
);

   nms_pkg::cell_type col_vec [WIN];
   nms_pkg::cell_type rd_data [WIN-1];
   nms_pkg::cell_type win_ff  [WIN][WIN];

   assign col_vec[0] = new_cell;

   for (genvar k = 0; k < WIN - 1; k++) begin : g_line
      nms_pkg::cell_type wr_data;
      if (k == 0) begin : g_first
         assign wr_data = new_cell;
      end else begin : g_next
         assign wr_data = rd_data[k-1];
      end
      nms_ram #(.DATA_W(nms_pkg::CELL_W), .DEPTH(MAX_WIDTH)) u_ram (
         .clock  (clock),
         .wr_en  (ctl.shift),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_en  (ctl.rd_en),
         .rd_addr(rd_addr),
         .rd_data(rd_data[k])
      );
      assign col_vec[k+1] = rd_data[k];
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int y = 0; y < WIN; y++) begin
            win_ff[y][0] <= col_vec[y];
            for (int x = 1; x < WIN; x++) begin
               win_ff[y][x] <= win_ff[y][x-1];
            end
         end
      end
   end

   assign win = win_ff;

endmodule

/* src/nms_judge.sv */
// Parallel neighbor compares over the window; gives the kept or suppressed value.
// Depends on nms_pkg.
module nms_judge #(
   parameter int WIN = 9
) (
   input  nms_pkg::cell_type                       win [WIN][WIN],
   input  logic [$clog2(WIN)-1:0]                  border,
   input  logic                                    fmt,
   output logic [nms_pkg::VALUE_W-1:0]             out_value
);

   nms_pkg::cell_type               center;
   logic signed [nms_pkg::VALUE_W:0] cv;
   logic                            beaten;
   logic                            keep;

   always_comb begin
      logic signed [nms_pkg::VALUE_W:0] nv;
      logic                             earlier;
      int                               b;
      b      = int'(border);
      center = win[b][b];
      cv     = nms_pkg::decode(center, fmt);
      beaten = 1'b0;
      for (int y = 0; y < WIN; y++) begin
         for (int x = 0; x < WIN; x++) begin
            nv      = nms_pkg::decode(win[y][x], fmt);
            earlier = (y > b) || ((y == b) && (x >= b));
            if ((y <= 2 * b) && (x <= 2 * b) && !win[y][x].mask) begin
               if (earlier ? (cv < nv) : (cv <= nv)) begin
                  beaten = 1'b1;
               end
            end
         end
      end
      keep = center.mask || !beaten;
      if (keep) begin
         out_value = cv[nms_pkg::VALUE_W-1:0];
      end else if (fmt == nms_pkg::FMT_U8) begin
         out_value = '0;
      end else begin
         out_value = nms_pkg::S16_FLOOR;
      end
   end

endmodule

/* src/windowed_non_max_suppression_core.sv */
// Windowed non-max suppression core: counters, pipeline control, config registers.
// Depends on nms_pkg, nms_lines, nms_judge.
//
// Pixels enter in raster order on the req_ channel (value plus mask bit), one per
// cycle at most. A transfer happens when valid is high and stall is low.
// For each pixel at least border = window_size/2 from every edge one result
// leaves on the rsp_ channel, issued when the pixel at (row+border, col+border)
// is taken; edge pixels give no result.
// rsp_valid rises once the result has passed the input stage with line store read,
// the window shift and the result register; a stall can hold it between them.
// Throughput is one pixel per cycle while req_stall is low, set by the line store
// RAMs, each read and written once per pixel on separate ports.
// rsp_stall holds the result register; the pipeline keeps taking pixels until
// its two internal stages fill, then req_stall rises.
// Reset empties the pipeline, zeroes the position counters and loads the
// registers with 640 x 480, window 3, unsigned 8-bit; line store contents are
// undefined until written. Configuration writes through csr_ are always taken
// and belong in idle periods.
module windowed_non_max_suppression_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_WINDOW = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [nms_pkg::VALUE_W-1:0]  req_pixel_value,
   input  logic                                req_mask_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [nms_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic [nms_pkg::OUT_COL_W-1:0]       rsp_out_col,
   output logic [nms_pkg::OUT_ROW_W-1:0]       rsp_out_row,
   output logic                                rsp_frame_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nms_pkg::CSR_DAT_W-1:0]       csr_data
);

   localparam int HALF = MAX_WINDOW / 2;
   localparam int WIN  = 2 * HALF + 1;
   localparam int BW   = $clog2(WIN);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int RW   = nms_pkg::HCFG_W;
   localparam int XW   = (WW > RW ? WW : RW) + 1;

   logic [nms_pkg::WCFG_W-1:0]  width_ff;
   logic [nms_pkg::HCFG_W-1:0]  height_ff;
   logic [nms_pkg::WSCFG_W-1:0] wsize_ff;
   logic                        fmt_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic               s1_v_ff, s2_v_ff, out_v_ff;
   nms_pkg::meta_type  s1_meta_ff, s1_meta_in, s2_meta_ff;
   nms_pkg::cell_type  s1_cell_ff;
   logic [CW-1:0]      s1_addr_ff;

   logic [nms_pkg::VALUE_W-1:0]   out_value_ff, judge_value;
   logic [nms_pkg::OUT_COL_W-1:0] out_col_ff;
   logic [nms_pkg::OUT_ROW_W-1:0] out_row_ff;
   logic                          out_last_ff;

   logic [WW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [BW-1:0] border;
   logic [XW-1:0] c_x, r_x, w_x, h_x, b2_x;
   logic          wrap, accept, out_free, s2_adv, s2_ready, s1_adv, s1_ready;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;

   nms_pkg::lines_ctl_type ctl;
   nms_pkg::cell_type      win [WIN][WIN];

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff == '0) ? RW'(1) : height_ff;
      if (32'(wsize_ff >> 1) > 32'(HALF)) begin
         border = BW'(HALF);
      end else begin
         border = BW'(wsize_ff >> 1);
      end
   end

   assign out_free = !out_v_ff || !rsp_stall;
   assign s2_adv   = s2_v_ff && (!s2_meta_ff.emit || out_free);
   assign s2_ready = !s2_v_ff || s2_adv;
   assign s1_adv   = s1_v_ff && s2_ready;
   assign s1_ready = !s1_v_ff || s1_adv;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   always_comb begin
      w_x  = XW'(w_eff);
      h_x  = XW'(h_eff);
      b2_x = XW'(border) << 1;
      wrap = (XW'(col_ff) >= w_x) || (XW'(row_ff) >= h_x);
      c_cur = wrap ? '0 : col_ff;
      r_cur = wrap ? '0 : row_ff;
      c_x = XW'(c_cur);
      r_x = XW'(r_cur);
      s1_meta_in.emit = (r_x >= b2_x) && (c_x >= b2_x);
      s1_meta_in.last = (c_x + XW'(1) == w_x) && (r_x + XW'(1) == h_x);
      s1_meta_in.col  = nms_pkg::OUT_COL_W'(c_x - XW'(border));
      s1_meta_in.row  = nms_pkg::OUT_ROW_W'(r_x - XW'(border));
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_x + XW'(1) >= w_x) begin
            col_in = '0;
            row_in = (r_x + XW'(1) >= h_x) ? '0 : RW'(r_x + XW'(1));
         end else begin
            col_in = CW'(c_x + XW'(1));
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nms_pkg::WCFG_W'(640);
         height_ff <= nms_pkg::HCFG_W'(480);
         wsize_ff  <= nms_pkg::WSCFG_W'(3);
         fmt_ff    <= nms_pkg::FMT_U8;
         col_ff    <= '0;
         row_ff    <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               nms_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data[nms_pkg::WCFG_W-1:0];
               nms_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data[nms_pkg::HCFG_W-1:0];
               nms_pkg::CSR_WINDOW_SIZE:  wsize_ff  <= csr_data[nms_pkg::WSCFG_W-1:0];
               nms_pkg::CSR_PIXEL_FORMAT: fmt_ff    <= csr_data[0];
               default: ;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         if (s1_ready) begin
            s1_v_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_free) begin
            out_v_ff <= s2_v_ff && s2_meta_ff.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff       <= s1_meta_in;
         s1_cell_ff.value <= req_pixel_value;
         s1_cell_ff.mask  <= req_mask_bit;
         s1_addr_ff       <= c_cur;
      end
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (s2_adv && s2_meta_ff.emit) begin
         out_value_ff <= judge_value;
         out_col_ff   <= s2_meta_ff.col;
         out_row_ff   <= s2_meta_ff.row;
         out_last_ff  <= s2_meta_ff.last;
      end
   end

   assign ctl.rd_en = accept;
   assign ctl.shift = s1_adv;

   nms_lines #(.MAX_WIDTH(MAX_WIDTH), .WIN(WIN)) u_lines (
      .clock   (clock),
      .ctl     (ctl),
      .rd_addr (c_cur),
      .wr_addr (s1_addr_ff),
      .new_cell(s1_cell_ff),
      .win     (win)
   );

   nms_judge #(.WIN(WIN)) u_judge (
      .win      (win),
      .border   (border),
      .fmt      (fmt_ff),
      .out_value(judge_value)
   );

   assign csr_ready      = 1'b1;
   assign rsp_valid      = out_v_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_frame_last = out_last_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_v_ff && !s1_v_ff && !s2_v_ff)
      else $error("pipeline not empty after reset");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_ready |=> s1_v_ff && $stable(s1_meta_ff))
      else $error("input stage lost a blocked item");

   a_emit_reaches_out: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && s2_meta_ff.emit && out_free |=> out_v_ff)
      else $error("interior result dropped");

   a_no_bubble_write: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |-> s1_v_ff)
      else $error("window shifted without an item");

endmodule
